@@ rtl/core/vrlp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrlp_pkg: shared types and constants
// Fixed widths, arithmetic constants and codes used by the vector RC low-pass
// filter with publish.
// ----------------------------------------------------------------------------
package vrlp_pkg;

  localparam int FRAC_W  = 16;
  localparam int AXIS_W  = 32;
  localparam int DT_W    = 16;
  localparam int FC_W    = 10;
  localparam int DTFC_W  = DT_W + FC_W;
  localparam int TPI_W   = 19;
  localparam int W_W     = 45;
  localparam int DEN_W   = 46;
  localparam int NUM_W   = W_W + FRAC_W;
  localparam int ALPHA_W = FRAC_W + 1;

  localparam int MUL_A_W = 27;
  localparam int MUL_B_W = TPI_W;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W + 1;

  localparam logic [FC_W-1:0]  DEFAULT_CUTOFF = 10'd5;
  localparam logic [TPI_W-1:0] TWO_PI_Q16     = 19'd411775;
  localparam logic [DEN_W-1:0] US_SCALED      = 46'd65536000000;

  localparam logic ACT_SAMPLE  = 1'b0;
  localparam logic ACT_PUBLISH = 1'b1;

  typedef logic [2:0][AXIS_W-1:0] vec3_t;

  typedef struct packed {
    logic filt_we;
    logic pub_we;
    logic fresh_set;
    logic fresh_clr;
  } store_wr_t;

endpackage

@@ rtl/core/vrlp_mul.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrlp_mul: shared multiplier
// Signed by unsigned multiplier with a registered product, reused for every
// multiplication of an item.
// ----------------------------------------------------------------------------
module vrlp_mul
  import vrlp_pkg::*;
(
  input  logic                      clk,
  input  logic signed [MUL_A_W-1:0] a,
  input  logic        [MUL_B_W-1:0] b,
  output logic signed [MUL_P_W-1:0] p
);

  always_ff @(posedge clk) begin
    p <= a * $signed({1'b0, b});
  end

endmodule

@@ rtl/core/vrlp_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrlp_div: iterative divider for the filter coefficient
// Restoring division producing one quotient bit per cycle. The quotient is
// known to fit in ALPHA_W bits.
// ----------------------------------------------------------------------------
module vrlp_div
  import vrlp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [NUM_W-1:0]   num,
  input  logic [DEN_W-1:0]   den,
  output logic               done,
  output logic [ALPHA_W-1:0] quo
);

  localparam int CNT_W = $clog2(ALPHA_W + 1);

  logic [DEN_W-1:0]   rem;
  logic [DEN_W-1:0]   dvs;
  logic [ALPHA_W-1:0] bits;
  logic [CNT_W-1:0]   cnt;
  logic               run;
  logic [DEN_W:0]     trial;
  logic               ge;

  assign trial = {rem, bits[ALPHA_W-1]};
  assign ge    = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem  <= DEN_W'(num[NUM_W-1:ALPHA_W]);
        bits <= num[ALPHA_W-1:0];
        dvs  <= den;
        cnt  <= CNT_W'(ALPHA_W);
        run  <= 1'b1;
      end else if (run) begin
        rem  <= ge ? DEN_W'(trial - {1'b0, dvs}) : DEN_W'(trial);
        quo  <= {quo[ALPHA_W-2:0], ge};
        bits <= {bits[ALPHA_W-2:0], 1'b0};
        cnt  <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

@@ rtl/core/vrlp_store.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrlp_store: per-instance filter state
// Filtered and published vectors with row valid bits, and the fresh flags.
// Rows never written read as zero.
// ----------------------------------------------------------------------------
module vrlp_store
  import vrlp_pkg::*;
#(
  parameter int INSTANCES = 8,
  parameter int IDX_W     = 3
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [IDX_W-1:0] rd_idx,
  output vec3_t            rd_filt,
  output vec3_t            rd_pub,
  output logic             rd_fresh,
  input  store_wr_t        wr,
  input  logic [IDX_W-1:0] wr_idx,
  input  vec3_t            wr_row
);

  vec3_t                filt_mem [INSTANCES];
  vec3_t                pub_mem  [INSTANCES];
  logic [INSTANCES-1:0] filt_vld;
  logic [INSTANCES-1:0] pub_vld;
  logic [INSTANCES-1:0] fresh;

  assign rd_filt  = filt_vld[rd_idx] ? filt_mem[rd_idx] : '0;
  assign rd_pub   = pub_vld[rd_idx] ? pub_mem[rd_idx] : '0;
  assign rd_fresh = fresh[rd_idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      filt_vld <= '0;
      pub_vld  <= '0;
      fresh    <= '0;
    end else begin
      if (wr.filt_we) begin
        filt_mem[wr_idx] <= wr_row;
        filt_vld[wr_idx] <= 1'b1;
      end
      if (wr.pub_we) begin
        pub_mem[wr_idx] <= wr_row;
        pub_vld[wr_idx] <= 1'b1;
      end
      if (wr.fresh_set) begin
        fresh[wr_idx] <= 1'b1;
      end else if (wr.fresh_clr) begin
        fresh[wr_idx] <= 1'b0;
      end
    end
  end

endmodule

@@ rtl/core/vector_rc_lowpass_publish_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector_rc_lowpass_publish_top: 3-axis RC low-pass filter with publish
// Per instance, filters raw samples in Q16.16 and publishes the filtered
// vector on request.
// ----------------------------------------------------------------------------
// A command beat is taken when start is high and busy is low. A sample beat
// (action 0) updates the instance's filtered vector and sets its fresh flag;
// a publish beat (action 1) copies the filtered vector to the published one
// when the flag is set, clears it, and returns the published vector.
// Each command yields exactly one result beat, marked by done for one cycle;
// the receiver must take it then, as there is no back-pressure.
// A publish, or a command for an absent instance, returns its result in the
// cycle after it is taken and busy stays low, so commands may follow back to
// back. A sample shows its result after two multiplier passes and the setup
// states S_DEN and S_NUM for the coefficient, the bit-serial divider, the
// states S_AXD to S_AXU per axis through the one shared multiplier and the
// write state S_WR; busy is high the whole time and drops as done rises.
// cutoff_hz is written with cutoff_we and should change only while idle.
// Reset clears all filter state, the fresh flags and the cutoff register.
// ----------------------------------------------------------------------------
module vector_rc_lowpass_publish_top
  import vrlp_pkg::*;
#(
  parameter int INSTANCES   = 8,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cutoff_we,
  input  logic [FC_W-1:0]               cutoff_hz,
  input  logic                          start,
  output logic                          busy,
  input  logic                          action,
  input  logic [2:0]                    instance_req,
  input  logic signed [SAMPLE_BITS-1:0] raw_x,
  input  logic signed [SAMPLE_BITS-1:0] raw_y,
  input  logic signed [SAMPLE_BITS-1:0] raw_z,
  input  logic [DT_W-1:0]               dt_us,
  output logic                          done,
  output logic signed [AXIS_W-1:0]      vec_x,
  output logic signed [AXIS_W-1:0]      vec_y,
  output logic signed [AXIS_W-1:0]      vec_z,
  output logic                          took_new
);

  localparam int IDX_W  = (INSTANCES > 1) ? $clog2(INSTANCES) : 1;
  localparam int RS_W   = SAMPLE_BITS + FRAC_W;
  localparam int DW     = ((RS_W > AXIS_W) ? RS_W : AXIS_W) + 1;
  localparam int ACC_W  = DW + ALPHA_W;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_M1   = 4'd1;
  localparam logic [3:0] S_M2   = 4'd2;
  localparam logic [3:0] S_DEN  = 4'd3;
  localparam logic [3:0] S_NUM  = 4'd4;
  localparam logic [3:0] S_DIV  = 4'd5;
  localparam logic [3:0] S_AXD  = 4'd6;
  localparam logic [3:0] S_AXL  = 4'd7;
  localparam logic [3:0] S_AXH  = 4'd8;
  localparam logic [3:0] S_AXS  = 4'd9;
  localparam logic [3:0] S_AXU  = 4'd10;
  localparam logic [3:0] S_WR   = 4'd11;

  logic [3:0]                    state;
  logic [FC_W-1:0]               cutoff;
  logic [IDX_W-1:0]              inst;
  logic signed [SAMPLE_BITS-1:0] raw [3];
  logic [DT_W-1:0]               dt;
  vec3_t                         f_row;
  vec3_t                         n_row;
  vec3_t                         out_row;
  logic [1:0]                    axis;
  logic [ALPHA_W-1:0]            alpha;
  logic [DEN_W-1:0]              den;
  logic [W_W-1:0]                w_hold;
  logic signed [DW-1:0]          d;
  logic signed [MUL_P_W-1:0]     lo;
  logic signed [ACC_W-1:0]       acc;

  logic [FC_W-1:0]               fc;
  logic [IDX_W-1:0]              idx_in;
  logic                          in_range;
  vec3_t                         rd_filt;
  vec3_t                         rd_pub;
  logic                          rd_fresh;
  store_wr_t                     wr;
  logic [IDX_W-1:0]              wr_idx;
  vec3_t                         wr_row;
  logic signed [MUL_A_W-1:0]     mul_a;
  logic        [MUL_B_W-1:0]     mul_b;
  logic signed [MUL_P_W-1:0]     mul_p;
  logic                          div_done;
  logic [ALPHA_W-1:0]            div_quo;
  logic [W_W-1:0]                w;
  logic [NUM_W-1:0]              num;
  logic signed [RS_W-1:0]        r_shift;
  logic signed [ACC_W-1:0]       nv;
  logic                          ovf;
  logic [AXIS_W-1:0]             sat_val;
  logic                          accept;

  assign busy     = state != S_IDLE;
  assign accept   = start && !busy;
  assign fc       = (cutoff == '0) ? DEFAULT_CUTOFF : cutoff;
  assign idx_in   = IDX_W'(instance_req);
  assign in_range = 32'(instance_req) < 32'(INSTANCES);
  assign vec_x    = out_row[0];
  assign vec_y    = out_row[1];
  assign vec_z    = out_row[2];

  assign w       = mul_p[W_W-1:0];
  assign num     = {w_hold, {FRAC_W{1'b0}}} + NUM_W'(den >> 1);
  assign r_shift = $signed({raw[axis], {FRAC_W{1'b0}}});
  assign nv      = ACC_W'($signed(f_row[axis])) + (acc >>> FRAC_W);
  assign ovf     = (nv[ACC_W-1:AXIS_W-1] != '0) && (nv[ACC_W-1:AXIS_W-1] != '1);
  assign sat_val = ovf ? (nv[ACC_W-1] ? {1'b1, {(AXIS_W-1){1'b0}}}
                                      : {1'b0, {(AXIS_W-1){1'b1}}})
                       : nv[AXIS_W-1:0];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_M1: begin
        mul_a = MUL_A_W'(dt);
        mul_b = MUL_B_W'(fc);
      end
      S_M2: begin
        mul_a = MUL_A_W'(mul_p[DTFC_W-1:0]);
        mul_b = TWO_PI_Q16;
      end
      S_AXL: begin
        mul_a = MUL_A_W'(d[FRAC_W-1:0]);
        mul_b = MUL_B_W'(alpha);
      end
      S_AXH: begin
        mul_a = MUL_A_W'($signed(d[DW-1:FRAC_W]));
        mul_b = MUL_B_W'(alpha);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    wr     = '0;
    wr_idx = inst;
    wr_row = n_row;
    if (state == S_IDLE) begin
      wr_idx = idx_in;
      wr_row = rd_filt;
      if (start && in_range && action == ACT_PUBLISH && rd_fresh) begin
        wr.pub_we    = 1'b1;
        wr.fresh_clr = 1'b1;
      end
    end else if (state == S_WR) begin
      wr.filt_we   = 1'b1;
      wr.fresh_set = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      cutoff   <= '0;
      done     <= 1'b0;
      took_new <= 1'b0;
    end else begin
      done     <= 1'b0;
      took_new <= 1'b0;
      if (cutoff_we) begin
        cutoff <= cutoff_hz;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (!in_range) begin
              done    <= 1'b1;
              out_row <= '0;
            end else if (action == ACT_PUBLISH) begin
              done     <= 1'b1;
              took_new <= rd_fresh;
              out_row  <= rd_fresh ? rd_filt : rd_pub;
            end else begin
              inst   <= idx_in;
              raw[0] <= raw_x;
              raw[1] <= raw_y;
              raw[2] <= raw_z;
              dt     <= dt_us;
              f_row  <= rd_filt;
              state  <= S_M1;
            end
          end
        end
        S_M1: state <= S_M2;
        S_M2: state <= S_DEN;
        S_DEN: begin
          den    <= DEN_W'(w) + US_SCALED;
          w_hold <= w;
          state  <= S_NUM;
        end
        S_NUM: state <= S_DIV;
        S_DIV: begin
          if (div_done) begin
            alpha <= div_quo;
            axis  <= 2'd0;
            state <= S_AXD;
          end
        end
        S_AXD: begin
          d     <= DW'(r_shift) - DW'($signed(f_row[axis]));
          state <= S_AXL;
        end
        S_AXL: state <= S_AXH;
        S_AXH: begin
          lo    <= mul_p;
          state <= S_AXS;
        end
        S_AXS: begin
          acc   <= (ACC_W'(mul_p) <<< FRAC_W) + ACC_W'(lo)
                   + ACC_W'(1 << (FRAC_W - 1));
          state <= S_AXU;
        end
        S_AXU: begin
          n_row[axis] <= sat_val;
          if (axis == 2'd2) begin
            state <= S_WR;
          end else begin
            axis  <= axis + 2'd1;
            state <= S_AXD;
          end
        end
        S_WR: begin
          done    <= 1'b1;
          out_row <= n_row;
          state   <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  vrlp_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  vrlp_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (state == S_NUM),
    .num   (num),
    .den   (den),
    .done  (div_done),
    .quo   (div_quo)
  );

  vrlp_store #(
    .INSTANCES (INSTANCES),
    .IDX_W     (IDX_W)
  ) u_store (
    .clk      (clk),
    .rst      (rst),
    .rd_idx   (idx_in),
    .rd_filt  (rd_filt),
    .rd_pub   (rd_pub),
    .rd_fresh (rd_fresh),
    .wr       (wr),
    .wr_idx   (wr_idx),
    .wr_row   (wr_row)
  );

endmodule

@@ rtl/core/vrlp_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrlp_checker: port-level checks
// Relates command beats, busy and result beats of the top level over time.
// ----------------------------------------------------------------------------
module vrlp_checker
  import vrlp_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic action,
  input logic done,
  input logic took_new
);

  a_busy_from_cmd: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a command beat");

  a_publish_next: assert property (@(posedge clk) disable iff (rst)
    start && !busy && action == ACT_PUBLISH |=> done && !busy)
    else $error("publish beat did not return a result in the next cycle");

  a_sample_ends_done: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done)
    else $error("sample finished without a result beat");

  a_no_done_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !done && !took_new)
    else $error("result beat while a sample is in progress");

  a_took_from_publish: assert property (@(posedge clk) disable iff (rst)
    took_new |-> done && $past(start && !busy && action == ACT_PUBLISH))
    else $error("took_new without a publish beat");

endmodule

bind vector_rc_lowpass_publish_top vrlp_checker u_vrlp_checker (
  .clk      (clk),
  .rst      (rst),
  .start    (start),
  .busy     (busy),
  .action   (action),
  .done     (done),
  .took_new (took_new)
);

@@ tb/sv/vrlp_filter_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrlp_filter_checker: scoreboard for the vector RC low-pass filter
// Watches the command, configuration and result ports, keeps its own copy of
// the filtered and published vectors, the fresh flags and the cutoff, works
// out the result of every accepted command and compares each result beat
// field by field with the oldest expected one.
// ----------------------------------------------------------------------------
module vrlp_filter_checker
  import vrlp_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cutoff_we,
  input  logic [FC_W-1:0]          cutoff_hz,
  input  logic                     start,
  input  logic                     busy,
  input  logic                     action,
  input  logic [2:0]               instance_req,
  input  logic signed [15:0]       raw_x,
  input  logic signed [15:0]       raw_y,
  input  logic signed [15:0]       raw_z,
  input  logic [DT_W-1:0]          dt_us,
  input  logic                     done,
  input  logic signed [AXIS_W-1:0] vec_x,
  input  logic signed [AXIS_W-1:0] vec_y,
  input  logic signed [AXIS_W-1:0] vec_z,
  input  logic                     took_new,
  output int                       mismatches,
  output int                       pending
);

  localparam int NUM_INST = 8;

  typedef struct packed {
    vec3_t axes;
    logic  took;
  } filt_result_t;

  logic signed [AXIS_W-1:0] filt_vec [NUM_INST][3];
  logic signed [AXIS_W-1:0] pub_vec  [NUM_INST][3];
  logic                     fresh    [NUM_INST];
  logic [FC_W-1:0]          cutoff_cur;
  filt_result_t             expected_results [$];

  function automatic longint alpha_q16(logic [DT_W-1:0] dt, logic [FC_W-1:0] fc_reg);
    longint unsigned fc;
    longint unsigned w;
    longint unsigned den;
    fc  = (fc_reg == '0) ? 64'(DEFAULT_CUTOFF) : 64'(fc_reg);
    w   = 64'(dt) * fc * 64'(TWO_PI_Q16);
    den = w + 64'(US_SCALED);
    return longint'(((w << 16) + den / 2) / den);
  endfunction

  function automatic logic signed [AXIS_W-1:0] smooth_axis(logic signed [AXIS_W-1:0] f,
                                                           logic signed [15:0] raw,
                                                           longint alpha);
    longint fl;
    longint d;
    longint p;
    longint nv;
    fl = f;
    d  = raw;
    d  = d * 65536 - fl;
    p  = d * alpha + 32768;
    nv = fl + (p >>> 16);
    if (nv > 64'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (nv < -64'sh8000_0000) return 32'sh8000_0000;
    return nv[AXIS_W-1:0];
  endfunction

  function automatic filt_result_t filter_command(logic act, logic [2:0] inst,
                                                  logic signed [15:0] rx,
                                                  logic signed [15:0] ry,
                                                  logic signed [15:0] rz,
                                                  logic [DT_W-1:0] dt);
    filt_result_t r;
    longint       al;
    r = '0;
    if (int'(inst) < NUM_INST) begin
      if (act == ACT_SAMPLE) begin
        al = alpha_q16(dt, cutoff_cur);
        filt_vec[inst][0] = smooth_axis(filt_vec[inst][0], rx, al);
        filt_vec[inst][1] = smooth_axis(filt_vec[inst][1], ry, al);
        filt_vec[inst][2] = smooth_axis(filt_vec[inst][2], rz, al);
        fresh[inst] = 1'b1;
        for (int a = 0; a < 3; a++) r.axes[a] = filt_vec[inst][a];
      end else begin
        if (fresh[inst]) begin
          for (int a = 0; a < 3; a++) pub_vec[inst][a] = filt_vec[inst][a];
          fresh[inst] = 1'b0;
          r.took = 1'b1;
        end
        for (int a = 0; a < 3; a++) r.axes[a] = pub_vec[inst][a];
      end
    end
    return r;
  endfunction

  initial begin
    mismatches = 0;
    pending    = 0;
  end

  always @(posedge clk) begin
    filt_result_t want;
    filt_result_t got;
    if (rst) begin
      for (int i = 0; i < NUM_INST; i++) begin
        for (int a = 0; a < 3; a++) begin
          filt_vec[i][a] = '0;
          pub_vec[i][a]  = '0;
        end
        fresh[i] = 1'b0;
      end
      cutoff_cur = '0;
      expected_results.delete();
    end else begin
      if (done) begin
        got.axes[0] = vec_x;
        got.axes[1] = vec_y;
        got.axes[2] = vec_z;
        got.took    = took_new;
        if (expected_results.size() == 0) begin
          $display("%0t: result beat with nothing expected: vec %0d %0d %0d took %0b",
                   $time, vec_x, vec_y, vec_z, took_new);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          for (int a = 0; a < 3; a++) begin
            if (got.axes[a] !== want.axes[a]) begin
              $display("%0t: axis %0d mismatch: expected %0d, actual %0d", $time, a,
                       $signed(want.axes[a]), $signed(got.axes[a]));
              mismatches++;
            end
          end
          if (got.took !== want.took) begin
            $display("%0t: took_new mismatch: expected %0b, actual %0b", $time,
                     want.took, got.took);
            mismatches++;
          end
        end
      end
      if (start && !busy) begin
        expected_results.push_back(filter_command(action, instance_req, raw_x, raw_y,
                                                  raw_z, dt_us));
      end
      if (cutoff_we) cutoff_cur = cutoff_hz;
    end
    pending = expected_results.size();
  end

endmodule

@@ tb/sv/tb_vector_rc_lowpass_publish_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_vector_rc_lowpass_publish_top: testbench for the vector RC low-pass filter
// Drives directed and random sample and publish commands in bursts with
// random gaps, under several cutoff settings, and lets the checker compare
// every result beat against its own prediction.
// ----------------------------------------------------------------------------
module tb_vector_rc_lowpass_publish_top;
  import vrlp_pkg::*;

  logic                     clk;
  logic                     rst;
  logic                     cutoff_we;
  logic [FC_W-1:0]          cutoff_hz;
  logic                     start;
  logic                     busy;
  logic                     action;
  logic [2:0]               instance_req;
  logic signed [15:0]       raw_x;
  logic signed [15:0]       raw_y;
  logic signed [15:0]       raw_z;
  logic [DT_W-1:0]          dt_us;
  logic                     done;
  logic signed [AXIS_W-1:0] vec_x;
  logic signed [AXIS_W-1:0] vec_y;
  logic signed [AXIS_W-1:0] vec_z;
  logic                     took_new;
  int                       mismatches;
  int                       pending;

  int burst_left;
  int cmds_sent;

  vector_rc_lowpass_publish_top u_dut (
    .clk          (clk),
    .rst          (rst),
    .cutoff_we    (cutoff_we),
    .cutoff_hz    (cutoff_hz),
    .start        (start),
    .busy         (busy),
    .action       (action),
    .instance_req (instance_req),
    .raw_x        (raw_x),
    .raw_y        (raw_y),
    .raw_z        (raw_z),
    .dt_us        (dt_us),
    .done         (done),
    .vec_x        (vec_x),
    .vec_y        (vec_y),
    .vec_z        (vec_z),
    .took_new     (took_new)
  );

  vrlp_filter_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .cutoff_we    (cutoff_we),
    .cutoff_hz    (cutoff_hz),
    .start        (start),
    .busy         (busy),
    .action       (action),
    .instance_req (instance_req),
    .raw_x        (raw_x),
    .raw_y        (raw_y),
    .raw_z        (raw_z),
    .dt_us        (dt_us),
    .done         (done),
    .vec_x        (vec_x),
    .vec_y        (vec_y),
    .vec_z        (vec_z),
    .took_new     (took_new),
    .mismatches   (mismatches),
    .pending      (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

  // Called at a falling edge; returns at a falling edge after the beat is taken.
  task automatic send_cmd(input logic act, input logic [2:0] inst,
                          input logic signed [15:0] rx, input logic signed [15:0] ry,
                          input logic signed [15:0] rz, input logic [DT_W-1:0] dt);
    start        = 1'b1;
    action       = act;
    instance_req = inst;
    raw_x        = rx;
    raw_y        = ry;
    raw_z        = rz;
    dt_us        = dt;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    cmds_sent++;
    if (burst_left == 0) begin
      start = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(20, 40) : $urandom_range(1, 8);
    end else begin
      burst_left--;
    end
  endtask

  task automatic drain;
    start = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_cutoff(input logic [FC_W-1:0] value);
    drain();
    cutoff_hz = value;
    cutoff_we = 1'b1;
    @(negedge clk);
    cutoff_we = 1'b0;
    @(negedge clk);
  endtask

  function automatic logic signed [15:0] pick_raw(logic signed [15:0] center);
    case ($urandom_range(0, 7))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2, 3:    return 16'($urandom);
      default: return center + 16'($urandom_range(0, 128)) - 16'sd64;
    endcase
  endfunction

  function automatic logic [DT_W-1:0] pick_dt();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 16'hFFFF;
      2, 3, 4: return 16'($urandom_range(1, 2000));
      5:       return 16'($urandom_range(2000, 20000));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_phase(input int count);
    int               target;
    logic [2:0]       inst;
    logic signed [15:0] center;
    target = cmds_sent + count;
    while (cmds_sent < target) begin
      if ($urandom_range(0, 9) < 7) begin
        inst   = 3'($urandom);
        center = 16'($urandom);
        repeat ($urandom_range(1, 4)) begin
          send_cmd(ACT_SAMPLE, inst, pick_raw(center), pick_raw(center), pick_raw(center),
                   pick_dt());
        end
        send_cmd(ACT_PUBLISH, inst, 16'($urandom), 16'($urandom), 16'($urandom),
                 16'($urandom));
        if ($urandom_range(0, 3) == 0) begin
          send_cmd(ACT_PUBLISH, inst, 16'($urandom), 16'($urandom), 16'($urandom),
                   16'($urandom));
        end
      end else begin
        send_cmd(1'($urandom), 3'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                 pick_dt());
      end
      if ($urandom_range(0, 39) == 0) drain();
    end
  endtask

  initial begin
    rst          = 1'b1;
    cutoff_we    = 1'b0;
    cutoff_hz    = '0;
    start        = 1'b0;
    action       = ACT_SAMPLE;
    instance_req = '0;
    raw_x        = '0;
    raw_y        = '0;
    raw_z        = '0;
    dt_us        = '0;
    burst_left   = 4;
    cmds_sent    = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    // Directed: reset state, zero elapsed time, flag handling, field extremes.
    send_cmd(ACT_PUBLISH, 3'd0, 16'sd0, 16'sd0, 16'sd0, 16'd0);
    send_cmd(ACT_SAMPLE, 3'd0, 16'sh7FFF, 16'sh8000, 16'sd1, 16'd0);
    send_cmd(ACT_PUBLISH, 3'd0, 16'sd0, 16'sd0, 16'sd0, 16'd0);
    send_cmd(ACT_PUBLISH, 3'd0, 16'sd0, 16'sd0, 16'sd0, 16'd0);
    send_cmd(ACT_SAMPLE, 3'd7, 16'sh7FFF, 16'sh8000, 16'sh5555, 16'hFFFF);
    send_cmd(ACT_SAMPLE, 3'd7, 16'sh7FFF, 16'sh8000, 16'shAAAA, 16'hFFFF);
    send_cmd(ACT_PUBLISH, 3'd7, 16'shFFFF, 16'shFFFF, 16'shFFFF, 16'hFFFF);
    send_cmd(ACT_SAMPLE, 3'd3, -16'sd1, 16'sd1, 16'sh5555, 16'd1);
    send_cmd(ACT_SAMPLE, 3'd3, 16'shAAAA, 16'sh5555, 16'sh8000, 16'h5555);
    send_cmd(ACT_SAMPLE, 3'd3, 16'sd0, 16'sd0, 16'sd0, 16'hAAAA);
    send_cmd(ACT_PUBLISH, 3'd3, 16'sd0, 16'sd0, 16'sd0, 16'd0);
    send_cmd(ACT_PUBLISH, 3'd5, 16'sd0, 16'sd0, 16'sd0, 16'd0);
    send_cmd(ACT_PUBLISH, 3'd7, 16'sd0, 16'sd0, 16'sd0, 16'd0);

    write_cutoff(10'd1023);
    send_cmd(ACT_SAMPLE, 3'd1, 16'sh8000, 16'sh7FFF, 16'sd0, 16'hFFFF);
    send_cmd(ACT_SAMPLE, 3'd1, 16'sh8000, 16'sh7FFF, 16'sd0, 16'd0);
    send_cmd(ACT_PUBLISH, 3'd1, 16'sd0, 16'sd0, 16'sd0, 16'd0);
    write_cutoff(10'd1);
    send_cmd(ACT_SAMPLE, 3'd2, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'd1);
    send_cmd(ACT_SAMPLE, 3'd2, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'hFFFF);
    send_cmd(ACT_PUBLISH, 3'd2, 16'sd0, 16'sd0, 16'sd0, 16'd0);

    write_cutoff(10'd1000);
    random_phase(120);
    write_cutoff(10'd1);
    random_phase(120);
    write_cutoff(10'd1023);
    random_phase(120);
    write_cutoff(10'd0);
    random_phase(120);
    write_cutoff(10'($urandom_range(2, 999)));
    random_phase(120);

    drain();
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
